// ===== rtl/core/eeg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and register indexes for the exponential envelope generator.
// Used by every module of the block; depends on nothing.
package eeg_pkg;

  localparam int LEVEL_W   = 24;
  localparam int COEF_W    = 24;
  localparam int HOLD_W    = 24;
  localparam int CURVE_W   = LEVEL_W + COEF_W;
  localparam int SUS_W     = LEVEL_W - 1;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [LEVEL_W-1:0] FULL_SCALE = {2'b01, {(LEVEL_W-2){1'b0}}};
  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX  = {1'b0, {(LEVEL_W-1){1'b1}}};
  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN  = {1'b1, {(LEVEL_W-1){1'b0}}};
  localparam logic signed [LEVEL_W-1:0] LEVEL_ZERO = '0;

  // Sustain reset is 0.7 of full scale, rounded.
  localparam longint SUS_RESET_INT = ((longint'(1) << (LEVEL_W-2)) * 7 + 5) / 10;
  localparam logic [SUS_W-1:0] SUS_RESET = SUS_W'(SUS_RESET_INT);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD    = 3'd5;

  typedef enum logic [1:0] {
    MODE_ADSR  = 2'd0,
    MODE_AHDSR = 2'd1,
    MODE_AHR   = 2'd2,
    MODE_AR    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    PH_OFF     = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_HOLD    = 3'd2,
    PH_DECAY   = 3'd3,
    PH_SUSTAIN = 3'd4,
    PH_RELEASE = 3'd5
  } phase_t;

  typedef struct packed {
    mode_t              mode;
    logic [CURVE_W-1:0] attack_crv;
    logic [CURVE_W-1:0] decay_crv;
    logic [CURVE_W-1:0] release_crv;
    logic [SUS_W-1:0]   sustain;
    logic [HOLD_W-1:0]  hold_samples;
  } cfg_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level;
    phase_t                    phase;
    logic                      gate_seen;
    logic [HOLD_W:0]           hold_count;
  } env_state_t;

endpackage

// ===== rtl/core/eeg_regs.sv =====
`timescale 1ns / 1ps
// Configuration register file of the envelope generator.
// Depends on eeg_pkg.
module eeg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [eeg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [eeg_pkg::CURVE_W-1:0]     cfg_data,
  output eeg_pkg::cfg_t                   cfg
);
  import eeg_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= MODE_ADSR;
      cfg.attack_crv   <= CURVE_W'(FULL_SCALE);
      cfg.decay_crv    <= '0;
      cfg.release_crv  <= '0;
      cfg.sustain      <= SUS_RESET;
      cfg.hold_samples <= '0;
    end else if (cfg_write) begin
      // Indexes beyond the list are dropped.
      case (cfg_index)
        REG_MODE:    cfg.mode         <= mode_t'(cfg_data[1:0]);
        REG_ATTACK:  cfg.attack_crv   <= cfg_data;
        REG_DECAY:   cfg.decay_crv    <= cfg_data;
        REG_RELEASE: cfg.release_crv  <= cfg_data;
        REG_SUSTAIN: cfg.sustain      <= cfg_data[SUS_W-1:0];
        REG_HOLD:    cfg.hold_samples <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/eeg_curve.sv =====
`timescale 1ns / 1ps
// One-pole curve step: floor(level * coef / 2^24) + offset, saturated to the level range.
// Depends on eeg_pkg.
module eeg_curve (
  input  logic signed [eeg_pkg::LEVEL_W-1:0] lvl,
  input  logic [eeg_pkg::CURVE_W-1:0]        crv,
  output logic signed [eeg_pkg::LEVEL_W-1:0] result
);
  import eeg_pkg::*;

  logic [COEF_W-1:0]                coef;
  logic signed [LEVEL_W-1:0]        offset;
  logic signed [LEVEL_W+COEF_W:0]   prod;
  logic signed [LEVEL_W:0]          scaled;
  logic signed [LEVEL_W+1:0]        sum;

  assign coef   = crv[CURVE_W-1 -: COEF_W];
  assign offset = signed'(crv[LEVEL_W-1:0]);
  assign prod   = lvl * signed'({1'b0, coef});
  // Dropping the low bits of a two's complement product rounds toward minus infinity.
  assign scaled = signed'(prod[LEVEL_W+COEF_W:COEF_W]);
  assign sum    = signed'({scaled[LEVEL_W], scaled}) +
                  signed'({{2{offset[LEVEL_W-1]}}, offset});

  always_comb begin
    if (sum[LEVEL_W+1:LEVEL_W-1] == 3'b000 || sum[LEVEL_W+1:LEVEL_W-1] == 3'b111) begin
      result = sum[LEVEL_W-1:0];
    end else if (sum[LEVEL_W+1]) begin
      result = LEVEL_MIN;
    end else begin
      result = LEVEL_MAX;
    end
  end

endmodule

// ===== rtl/core/eeg_step.sv =====
`timescale 1ns / 1ps
// Next-state logic of the envelope: gate edge handling and the per-sample phase update.
// Depends on eeg_pkg and eeg_curve.
module eeg_step (
  input  logic                action,
  input  logic                gate,
  input  eeg_pkg::cfg_t       cfg,
  input  eeg_pkg::env_state_t cur,
  output eeg_pkg::env_state_t nxt
);
  import eeg_pkg::*;

  logic                      short_mode;
  logic [CURVE_W-1:0]        crv_sel;
  logic signed [LEVEL_W-1:0] crv_out;
  logic signed [LEVEL_W-1:0] sus_ext;
  logic signed [LEVEL_W-1:0] sus_val;

  assign short_mode = (cfg.mode == MODE_AHR) || (cfg.mode == MODE_AR);
  assign sus_ext    = signed'({1'b0, cfg.sustain});
  assign sus_val    = (sus_ext > FULL_SCALE) ? FULL_SCALE : sus_ext;

  always_comb begin
    unique case (cur.phase)
      PH_ATTACK: crv_sel = cfg.attack_crv;
      PH_DECAY:  crv_sel = cfg.decay_crv;
      default:   crv_sel = cfg.release_crv;
    endcase
  end

  eeg_curve u_curve (
    .lvl    (cur.level),
    .crv    (crv_sel),
    .result (crv_out)
  );

  always_comb begin
    nxt = cur;
    if (action) begin
      unique case (cur.phase)
        PH_ATTACK: begin
          nxt.level = crv_out;
          if (crv_out >= FULL_SCALE) begin
            unique case (cfg.mode)
              MODE_ADSR:              nxt.phase = PH_DECAY;
              MODE_AR:                nxt.phase = PH_RELEASE;
              MODE_AHDSR, MODE_AHR:   nxt.phase = PH_HOLD;
            endcase
          end
        end
        PH_HOLD: begin
          // Hold only counts in the modes that have a hold phase.
          if (cfg.mode == MODE_AHDSR || cfg.mode == MODE_AHR) begin
            if (cur.hold_count > {1'b0, cfg.hold_samples}) begin
              nxt.phase      = (cfg.mode == MODE_AHDSR) ? PH_DECAY : PH_RELEASE;
              nxt.hold_count = '0;
            end else begin
              nxt.hold_count = cur.hold_count + (HOLD_W+1)'(1);
            end
          end
        end
        PH_DECAY: begin
          if (!short_mode) begin
            if (crv_out <= sus_val) begin
              nxt.level = sus_val;
              nxt.phase = PH_SUSTAIN;
            end else begin
              nxt.level = crv_out;
            end
          end
        end
        PH_SUSTAIN: begin
          if (!short_mode) begin
            nxt.level = sus_val;
          end
        end
        PH_RELEASE: begin
          if (crv_out <= LEVEL_ZERO) begin
            nxt.level = LEVEL_ZERO;
            nxt.phase = PH_OFF;
            if (short_mode) begin
              nxt.gate_seen = 1'b0;
            end
          end else begin
            nxt.level = crv_out;
          end
        end
        default: ;
      endcase
    end else begin
      if (gate && !cur.gate_seen) begin
        nxt.phase      = PH_ATTACK;
        nxt.hold_count = '0;
      end else if (!gate && cur.gate_seen) begin
        nxt.phase = PH_RELEASE;
      end
      // Short modes never remember the gate, so every high gate retriggers.
      nxt.gate_seen = short_mode ? 1'b0 : gate;
    end
  end

endmodule

// ===== rtl/core/exponential_envelope_generator_top.sv =====
`timescale 1ns / 1ps
// Top level of the exponential envelope generator (ADSR, AHDSR, AHR, AR).
// Depends on eeg_pkg, eeg_regs, eeg_step and eeg_curve.
//
//   Channel   Handshake              Payload
//   --------  ---------------------  ------------------------------------
//   input     in_valid / in_stall    action, gate
//   output    out_valid / out_stall  level, phase, busy_res
//   config    cfg_write              cfg_index, cfg_data (no read-back)
//
// Each input transaction yields exactly one output transaction. The block
// takes one transaction per cycle unless the output stalls; each one passes
// through the input register, then the curve multiply-add into the result
// register. Reset (rst, synchronous, active high) clears the envelope state,
// both pipeline valids and loads the register defaults. A stalled output holds
// its result; the input register then fills and in_stall rises until space frees.
module exponential_envelope_generator_top (
  input  logic                               clk,
  input  logic                               rst,
  // Input channel.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               action,
  input  logic                               gate,
  // Output channel.
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [eeg_pkg::LEVEL_W-1:0] level,
  output logic [2:0]                         phase,
  output logic                               busy_res,
  // Configuration write port.
  input  logic                               cfg_write,
  input  logic [eeg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [eeg_pkg::CURVE_W-1:0]        cfg_data
);
  import eeg_pkg::*;

  cfg_t       cfg;
  env_state_t state;
  env_state_t state_next;

  // Input register.
  logic in_full;
  logic in_action;
  logic in_gate;
  logic in_take;
  logic advance;

  eeg_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held transaction moves on when the result register is empty or is
  // being emptied in this same cycle.
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_action <= action;
      in_gate   <= gate;
    end
  end

  eeg_step u_step (
    .action (in_action),
    .gate   (in_gate),
    .cfg    (cfg),
    .cur    (state),
    .nxt    (state_next)
  );

  // Envelope state is committed only when a transaction is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.level      <= '0;
      state.phase      <= PH_OFF;
      state.gate_seen  <= 1'b0;
      state.hold_count <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      level    <= state_next.level;
      phase    <= state_next.phase;
      busy_res <= (state_next.phase != PH_OFF);
    end
  end

endmodule

// ===== rtl/core/eeg_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the envelope generator, attached to the top level by bind.
// Depends on eeg_pkg.
module eeg_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [eeg_pkg::LEVEL_W-1:0] level,
  input logic [2:0]                         phase,
  input logic                               busy_res
);
  import eeg_pkg::*;

  // The busy flag mirrors the phase.
  a_busy_matches_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (busy_res == (phase != PH_OFF)))
    else $error("busy_res disagrees with phase");

  // The envelope only reaches the off phase with its level at zero.
  a_off_level_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && phase == PH_OFF) |-> (level == LEVEL_ZERO))
    else $error("nonzero level while off");

  // A stalled result stays in place.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(level) && $stable(phase)))
    else $error("result changed under stall");

endmodule

bind exponential_envelope_generator_top eeg_checker u_eeg_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .level     (level),
  .phase     (phase),
  .busy_res  (busy_res)
);
